// ----- rtl/core/mcbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Coil bank server package
// Shared constants, codes and types of the coil bank server core.
// ----------------------------------------------------------------------------
package mcbs_pkg;

    // Size defaults of the coil bank.
    localparam int MAX_COILS_DEF     = 1024;
    localparam int MAX_REQ_COILS_DEF = 64;

    // The coil store is kept as rows of 64 coils, one request window wide.
    localparam int ROW_W  = 64;
    localparam int ROW_SH = 6;
    // Width that holds a coil address plus a coil count without overflow.
    localparam int CMP_W  = 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COILS_IN_USE  = 1'b1;
    localparam logic [7:0] SLAVE_ADDRESS_RST = 8'd1;
    localparam int COILS_IN_USE_RST = 1024;

    // Request modes.
    localparam logic [1:0] MODE_READ         = 2'd0;
    localparam logic [1:0] MODE_WRITE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_WRITE_MULTI  = 2'd2;
    localparam logic [1:0] MODE_UNUSED       = 2'd3;

    // Response status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ADDR  = 2'd1;
    localparam logic [1:0] ST_VALUE = 2'd2;

    // Legal write single values.
    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    // Write request to one bank of rows.
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] data;
    } bank_wr_t;

    // Rows produced by the merge stage.
    typedef struct packed {
        logic [ROW_W-1:0] window;
        logic [ROW_W-1:0] even_row;
        logic [ROW_W-1:0] odd_row;
    } merge_out_t;

endpackage

// ----- rtl/core/modbus_coil_bank_server_core.sv -----
// ----------------------------------------------------------------------------
// Coil bank server core
// Serves read coils, write single coil and write multiple coils requests
// against a bank of one-bit coils held as 64-coil rows in two bank lanes.
//
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  mode ... write_bits
// response  out        out_valid / out_stall resp_address ... echo_word
// config    in         cfg_we               cfg_index, cfg_data
//
// A request is accepted with a read of both bank lanes; when the merge stage
// advances, the rows are merged, written back and the response register
// loaded. No new request is taken while one sits in the merge stage; the
// read-modify-write of the bank rows is the reason for this.
// After reset the banks are swept clear, all 2**BANK_AW rows per lane (8 with
// the default sizes), and no request is taken until that is done.
// A stalled response holds the next request in the merge stage.
// ----------------------------------------------------------------------------
module modbus_coil_bank_server_core #(
    parameter int MAX_COILS     = mcbs_pkg::MAX_COILS_DEF,
    parameter int MAX_REQ_COILS = mcbs_pkg::MAX_REQ_COILS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mcbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic [7:0]                      unit_address,
    input  logic [15:0]                     first_coil,
    input  logic [15:0]                     coil_count,
    input  logic [15:0]                     single_value,
    input  logic [7:0]                      byte_count,
    input  logic [63:0]                     write_bits,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      resp_address,
    output logic [1:0]                      resp_function,
    output logic [1:0]                      status,
    output logic [3:0]                      resp_byte_count,
    output logic [63:0]                     read_bits,
    output logic [15:0]                     echo_first,
    output logic [15:0]                     echo_word
);

    localparam int ROW_W   = mcbs_pkg::ROW_W;
    localparam int ROWS    = (MAX_COILS + ROW_W - 1) / ROW_W;
    localparam int BANK_AW = ($clog2(ROWS) > 1) ? ($clog2(ROWS) - 1) : 1;
    localparam int ROW_AW  = BANK_AW + 1;
    localparam int LIVE_W  = $clog2(MAX_COILS + 1);
    localparam int CMP_W   = mcbs_pkg::CMP_W;
    localparam int LIVE_RST = (mcbs_pkg::COILS_IN_USE_RST < MAX_COILS)
                              ? mcbs_pkg::COILS_IN_USE_RST : MAX_COILS;

    // Configuration.
    logic [7:0]        slave_addr_reg;
    logic [7:0]        slave_addr_next;
    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] live_next;
    logic [CMP_W-1:0]  cfg_coils;

    // Request decode.
    logic              accept;
    logic [CMP_W-1:0]  first_x;
    logic [CMP_W-1:0]  count_x;
    logic [CMP_W-1:0]  live_x;
    logic              window_ok;
    logic              count_big;
    logic              bytes_bad;
    logic [1:0]        req_status;
    logic              req_write;
    logic              req_read_ok;
    logic              req_resp;
    logic [ROW_W-1:0]  req_mask;
    logic [ROW_W-1:0]  req_wdata;
    logic [3:0]        req_rbytes;
    logic [15:0]       req_efirst;
    logic [15:0]       req_eword;
    logic [6:0]        count_m1;
    logic [ROW_AW-1:0] row0;
    logic [ROW_AW-1:0] row1;
    logic [BANK_AW-1:0] even_addr;
    logic [BANK_AW-1:0] odd_addr;

    // Merge stage.
    logic               stg_valid_reg;
    logic               stg_valid_next;
    logic               stg_resp_reg;
    logic [1:0]         stg_mode_reg;
    logic [1:0]         stg_status_reg;
    logic               stg_write_reg;
    logic               stg_read_ok_reg;
    logic               stg_lsb_reg;
    logic [mcbs_pkg::ROW_SH-1:0] stg_offset_reg;
    logic [ROW_W-1:0]   stg_mask_reg;
    logic [ROW_W-1:0]   stg_wdata_reg;
    logic [3:0]         stg_rbytes_reg;
    logic [15:0]        stg_efirst_reg;
    logic [15:0]        stg_eword_reg;
    logic [BANK_AW-1:0] stg_even_addr_reg;
    logic [BANK_AW-1:0] stg_odd_addr_reg;
    logic               advance;

    // Response register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         resp_address_reg;
    logic [1:0]         resp_function_reg;
    logic [1:0]         status_reg;
    logic [3:0]         resp_byte_count_reg;
    logic [63:0]        read_bits_reg;
    logic [15:0]        echo_first_reg;
    logic [15:0]        echo_word_reg;

    // Lanes.
    logic [ROW_W-1:0]     even_rd;
    logic [ROW_W-1:0]     odd_rd;
    logic                 even_clr;
    logic                 odd_clr;
    mcbs_pkg::bank_wr_t   even_wr;
    mcbs_pkg::bank_wr_t   odd_wr;
    mcbs_pkg::merge_out_t merged;

    // ------------------------------------------------------------------
    // Configuration registers. The live coil count is kept already
    // limited to the size of the bank.
    // ------------------------------------------------------------------
    always_comb
    begin
        slave_addr_next = slave_addr_reg;
        live_next       = live_reg;
        cfg_coils       = CMP_W'(cfg_data);
        if (cfg_we)
        begin
            case (cfg_index)
                mcbs_pkg::REG_SLAVE_ADDRESS:
                begin
                    slave_addr_next = cfg_data[7:0];
                end
                mcbs_pkg::REG_COILS_IN_USE:
                begin
                    live_next = (cfg_coils < CMP_W'(MAX_COILS))
                                ? LIVE_W'(cfg_coils) : LIVE_W'(MAX_COILS);
                end
                default:
                begin
                    slave_addr_next = slave_addr_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request checks, in the order the protocol gives them.
    // ------------------------------------------------------------------
    always_comb
    begin
        first_x   = CMP_W'(first_coil);
        count_x   = CMP_W'(coil_count);
        live_x    = CMP_W'(live_reg);
        window_ok = (count_x <= live_x) && (first_x < live_x)
                    && ((first_x + count_x) <= live_x);
        count_big = coil_count > 16'(MAX_REQ_COILS);
        bytes_bad = 16'(byte_count) != (((coil_count - 16'd1) >> 3) + 16'd1);
        count_m1  = coil_count[6:0] - 7'd1;

        req_status = mcbs_pkg::ST_OK;
        case (mode)
            mcbs_pkg::MODE_READ:
            begin
                if (coil_count == 16'd0 || count_big)
                    req_status = mcbs_pkg::ST_VALUE;
                else if (!window_ok)
                    req_status = mcbs_pkg::ST_ADDR;
            end
            mcbs_pkg::MODE_WRITE_SINGLE:
            begin
                if (first_x >= live_x)
                    req_status = mcbs_pkg::ST_ADDR;
                else if (single_value != mcbs_pkg::COIL_OFF
                         && single_value != mcbs_pkg::COIL_ON)
                    req_status = mcbs_pkg::ST_VALUE;
            end
            mcbs_pkg::MODE_WRITE_MULTI:
            begin
                if (byte_count == 8'd0 || coil_count == 16'd0)
                    req_status = mcbs_pkg::ST_VALUE;
                else if (bytes_bad || count_big)
                    req_status = mcbs_pkg::ST_VALUE;
                else if (!window_ok)
                    req_status = mcbs_pkg::ST_ADDR;
            end
            default:
            begin
                req_status = mcbs_pkg::ST_OK;
            end
        endcase

        req_read_ok = (mode == mcbs_pkg::MODE_READ) && (req_status == mcbs_pkg::ST_OK);
        req_write   = (req_status == mcbs_pkg::ST_OK)
                      && (mode == mcbs_pkg::MODE_WRITE_SINGLE
                          || mode == mcbs_pkg::MODE_WRITE_MULTI);
        req_resp    = (unit_address != 8'd0) && (mode != mcbs_pkg::MODE_UNUSED);

        // A legal window holds at most 64 coils, so bit 6 set means all 64.
        if (mode == mcbs_pkg::MODE_WRITE_SINGLE)
        begin
            req_mask  = ROW_W'(1);
            req_wdata = ROW_W'(single_value == mcbs_pkg::COIL_ON);
        end
        else
        begin
            req_mask  = coil_count[6] ? {ROW_W{1'b1}}
                                      : ((ROW_W'(1) << coil_count[5:0]) - ROW_W'(1));
            req_wdata = write_bits;
        end

        req_rbytes = req_read_ok ? (4'(count_m1 >> 3) + 4'd1) : 4'd0;
        req_efirst = req_write ? first_coil : 16'd0;
        req_eword  = 16'd0;
        if (req_write)
        begin
            req_eword = (mode == mcbs_pkg::MODE_WRITE_SINGLE) ? single_value : coil_count;
        end

        // The window touches rows row0 and row0 + 1: one in each bank.
        row0      = first_coil[mcbs_pkg::ROW_SH +: ROW_AW];
        row1      = row0 + ROW_AW'(1);
        even_addr = row1[ROW_AW-1:1];
        odd_addr  = row0[ROW_AW-1:1];
    end

    // ------------------------------------------------------------------
    // Handshake and stage control.
    // ------------------------------------------------------------------
    assign in_stall = even_clr || odd_clr || stg_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign advance  = stg_valid_reg && !(out_valid_reg && out_stall);

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (accept)
            stg_valid_next = 1'b1;
        else if (advance)
            stg_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && stg_resp_reg)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= mcbs_pkg::SLAVE_ADDRESS_RST;
            live_reg       <= LIVE_W'(LIVE_RST);
            stg_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slave_addr_reg <= slave_addr_next;
            live_reg       <= live_next;
            stg_valid_reg  <= stg_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_resp_reg      <= req_resp;
            stg_mode_reg      <= mode;
            stg_status_reg    <= req_status;
            stg_write_reg     <= req_write;
            stg_read_ok_reg   <= req_read_ok;
            stg_lsb_reg       <= row0[0];
            stg_offset_reg    <= first_coil[mcbs_pkg::ROW_SH-1:0];
            stg_mask_reg      <= req_mask;
            stg_wdata_reg     <= req_wdata;
            stg_rbytes_reg    <= req_rbytes;
            stg_efirst_reg    <= req_efirst;
            stg_eword_reg     <= req_eword;
            stg_even_addr_reg <= even_addr;
            stg_odd_addr_reg  <= odd_addr;
        end
        if (advance && stg_resp_reg)
        begin
            resp_address_reg    <= slave_addr_reg;
            resp_function_reg   <= stg_mode_reg;
            status_reg          <= stg_status_reg;
            resp_byte_count_reg <= stg_rbytes_reg;
            read_bits_reg       <= stg_read_ok_reg ? merged.window : 64'd0;
            echo_first_reg      <= stg_efirst_reg;
            echo_word_reg       <= stg_eword_reg;
        end
    end

    // ------------------------------------------------------------------
    // Bank lanes and merge stage.
    // ------------------------------------------------------------------
    always_comb
    begin
        even_wr.en   = advance && stg_write_reg;
        even_wr.data = merged.even_row;
        odd_wr.en    = advance && stg_write_reg;
        odd_wr.data  = merged.odd_row;
    end

    mcbs_bank #(
        .BANK_AW (BANK_AW)
    ) u_even_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (even_addr),
        .wr_addr  (stg_even_addr_reg),
        .wr       (even_wr),
        .rd_data  (even_rd),
        .clr_busy (even_clr)
    );

    mcbs_bank #(
        .BANK_AW (BANK_AW)
    ) u_odd_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (odd_addr),
        .wr_addr  (stg_odd_addr_reg),
        .wr       (odd_wr),
        .rd_data  (odd_rd),
        .clr_busy (odd_clr)
    );

    mcbs_merge u_merge (
        .even_row (even_rd),
        .odd_row  (odd_rd),
        .row_lsb  (stg_lsb_reg),
        .offset   (stg_offset_reg),
        .mask     (stg_mask_reg),
        .wdata    (stg_wdata_reg),
        .result   (merged)
    );

    assign out_valid       = out_valid_reg;
    assign resp_address    = resp_address_reg;
    assign resp_function   = resp_function_reg;
    assign status          = status_reg;
    assign resp_byte_count = resp_byte_count_reg;
    assign read_bits       = read_bits_reg;
    assign echo_first      = echo_first_reg;
    assign echo_word       = echo_word_reg;

endmodule

// ----- rtl/core/mcbs_bank.sv -----
// ----------------------------------------------------------------------------
// Coil bank lane
// One bank of 64-coil rows with a registered read port, a write port and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module mcbs_bank #(
    parameter int BANK_AW = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [BANK_AW-1:0]        rd_addr,
    input  logic [BANK_AW-1:0]        wr_addr,
    input  mcbs_pkg::bank_wr_t        wr,
    output logic [mcbs_pkg::ROW_W-1:0] rd_data,
    output logic                      clr_busy
);

    localparam int DEPTH = 2 ** BANK_AW;

    logic [mcbs_pkg::ROW_W-1:0] mem [DEPTH];
    logic [mcbs_pkg::ROW_W-1:0] rd_data_reg;
    logic [BANK_AW-1:0]         clr_addr_reg;
    logic [BANK_AW-1:0]         clr_addr_next;
    logic                       clr_busy_reg;
    logic                       clr_busy_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + BANK_AW'(1);
            clr_busy_next = (clr_addr_reg != {BANK_AW{1'b1}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ----- rtl/core/mcbs_merge.sv -----
// ----------------------------------------------------------------------------
// Coil bank merge stage
// Joins the rows found by the two bank lanes into the request window and
// builds the updated rows for a write.
// ----------------------------------------------------------------------------
module mcbs_merge (
    input  logic [mcbs_pkg::ROW_W-1:0]  even_row,
    input  logic [mcbs_pkg::ROW_W-1:0]  odd_row,
    input  logic                        row_lsb,
    input  logic [mcbs_pkg::ROW_SH-1:0] offset,
    input  logic [mcbs_pkg::ROW_W-1:0]  mask,
    input  logic [mcbs_pkg::ROW_W-1:0]  wdata,
    output mcbs_pkg::merge_out_t        result
);

    localparam int PAIR_W = 2 * mcbs_pkg::ROW_W;

    logic [mcbs_pkg::ROW_W-1:0] lo_row;
    logic [mcbs_pkg::ROW_W-1:0] hi_row;
    logic [PAIR_W-1:0]          pair;
    logic [PAIR_W-1:0]          pair_shr;
    logic [PAIR_W-1:0]          mask_pair;
    logic [PAIR_W-1:0]          data_pair;
    logic [PAIR_W-1:0]          new_pair;

    // The window starts in the lower row, which sits in the odd bank when
    // the first row number is odd.
    always_comb
    begin
        lo_row    = row_lsb ? odd_row : even_row;
        hi_row    = row_lsb ? even_row : odd_row;
        pair      = {hi_row, lo_row};
        pair_shr  = pair >> offset;
        mask_pair = {{mcbs_pkg::ROW_W{1'b0}}, mask} << offset;
        data_pair = {{mcbs_pkg::ROW_W{1'b0}}, wdata & mask} << offset;
        new_pair  = (pair & ~mask_pair) | data_pair;

        result.window   = pair_shr[mcbs_pkg::ROW_W-1:0] & mask;
        result.even_row = row_lsb ? new_pair[PAIR_W-1:mcbs_pkg::ROW_W]
                                  : new_pair[mcbs_pkg::ROW_W-1:0];
        result.odd_row  = row_lsb ? new_pair[mcbs_pkg::ROW_W-1:0]
                                  : new_pair[PAIR_W-1:mcbs_pkg::ROW_W];
    end

endmodule
